// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

  localparam int unsigned DefWidth = 32;
  localparam int unsigned IoWidth  = 32;
  localparam int unsigned OpWidth  = 3;

  localparam logic [OpWidth-1:0] OP_ADD = 3'd0;
  localparam logic [OpWidth-1:0] OP_SUB = 3'd1;
  localparam logic [OpWidth-1:0] OP_MUL = 3'd2;
  localparam logic [OpWidth-1:0] OP_DIV = 3'd3;

  // Command to the shared divider and its completion status.
  typedef struct packed {
    logic start;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/rau_div.sv =====
module rau_div #(
  parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rau_pkg::div_cmd_t       cmd,
  input  logic signed [WIDTH-1:0] dividend,
  input  logic signed [WIDTH-1:0] divisor,
  output rau_pkg::div_stat_t      stat,
  output logic signed [WIDTH-1:0] quot,
  output logic signed [WIDTH-1:0] rem
);
  import rau_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] p_r, p_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic             qneg_r, qneg_nxt;
  logic             rneg_r, rneg_nxt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   shifted;

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    p_nxt    = p_r;
    d_nxt    = d_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    shifted  = {p_r, q_r[WIDTH-1]};
    trial    = shifted - {1'b0, d_r};
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(WIDTH);
      q_nxt    = dividend[WIDTH-1] ? -dividend : dividend;
      d_nxt    = divisor[WIDTH-1] ? -divisor : divisor;
      p_nxt    = '0;
      qneg_nxt = dividend[WIDTH-1] ^ divisor[WIDTH-1];
      rneg_nxt = dividend[WIDTH-1];
    end else if (busy_r) begin
      if (!trial[WIDTH]) begin
        p_nxt = trial[WIDTH-1:0];
        q_nxt = {q_r[WIDTH-2:0], 1'b1};
      end else begin
        p_nxt = shifted[WIDTH-1:0];
        q_nxt = {q_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    p_r    <= p_nxt;
    d_r    <= d_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign quot = qneg_r ? -q_r : q_r;
  assign rem  = rneg_r ? -p_r : p_r;
  assign stat = '{busy: busy_r, done: done_r};
endmodule

// ===== rtl/core/rau_seq.sv =====
module rau_seq #(
  parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rau_pkg::OpWidth-1:0]     in_op,
  input  logic signed [rau_pkg::IoWidth-1:0] in_a_num,
  input  logic signed [rau_pkg::IoWidth-1:0] in_a_den,
  input  logic signed [rau_pkg::IoWidth-1:0] in_b_num,
  input  logic signed [rau_pkg::IoWidth-1:0] in_b_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [rau_pkg::IoWidth-1:0] out_res_num,
  output logic signed [rau_pkg::IoWidth-1:0] out_res_den,
  output logic                            out_res_zero,
  output rau_pkg::div_cmd_t               dcmd,
  output logic signed [WIDTH-1:0]         dvd,
  output logic signed [WIDTH-1:0]         dvs,
  input  rau_pkg::div_stat_t              dstat,
  input  logic signed [WIDTH-1:0]         dquot,
  input  logic signed [WIDTH-1:0]         drem
);
  import rau_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MUL0 = 11'b00000000010,
    S_MUL1 = 11'b00000000100,
    S_MUL2 = 11'b00000001000,
    S_COMB = 11'b00000010000,
    S_GCD  = 11'b00000100000,
    S_GWT  = 11'b00001000000,
    S_DVN  = 11'b00010000000,
    S_DVD  = 11'b00100000000,
    S_FIN  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t                  st_r, st_nxt;
  logic [OpWidth-1:0]      op_r;
  logic signed [WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [WIDTH-1:0] p0_r, p1_r, p2_r;
  logic signed [WIDTH-1:0] rn_r, rd_r, x_r, y_r, g_r;
  logic signed [WIDTH-1:0] mx, my, mp;
  logic signed [WIDTH-1:0] neg_one;

  function automatic logic signed [WIDTH-1:0] wext(input logic signed [IoWidth-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[WIDTH-1:0];
  endfunction

  function automatic logic signed [IoWidth-1:0] oext(input logic signed [WIDTH-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[IoWidth-1:0];
  endfunction

  assign neg_one = '1;

  // One shared multiplier, registered after use.
  always_comb begin
    mx = an_r;
    my = bd_r;
    unique case (st_r)
      S_MUL1: begin
        mx = (op_r == OP_MUL) ? an_r : bn_r;
        my = (op_r == OP_MUL) ? bn_r : ((op_r == OP_DIV) ? ad_r : ad_r);
      end
      S_MUL2: begin
        mx = ad_r;
        my = (op_r == OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mx = an_r;
        my = bd_r;
      end
    endcase
  end
  assign mp = WIDTH'(mx * my);

  always_comb begin
    st_nxt   = st_r;
    dcmd     = '{start: 1'b0};
    dvd      = x_r;
    dvs      = y_r;
    unique case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_MUL0;
      S_MUL0: st_nxt = S_MUL1;
      S_MUL1: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_COMB;
      S_COMB: st_nxt = S_GCD;
      S_GCD: begin
        if (rn_r == '0 || rd_r == '0) st_nxt = S_OUT;
        else if (x_r == '0 || y_r == '0) begin
          st_nxt = S_DVN;
        end else if (y_r == neg_one) begin
          st_nxt = S_GCD;
        end else begin
          dcmd   = '{start: 1'b1};
          st_nxt = S_GWT;
        end
      end
      S_GWT: if (dstat.done) st_nxt = S_GCD;
      S_DVN: begin
        dvd = rn_r;
        dvs = g_r;
        if (g_r == neg_one) st_nxt = S_DVD;
        else begin
          dcmd   = '{start: 1'b1};
          st_nxt = S_DVD;
        end
      end
      S_DVD: begin
        dvd = rd_r;
        dvs = g_r;
        if (g_r == neg_one) st_nxt = S_FIN;
        else if (dstat.done) begin
          dcmd   = '{start: 1'b1};
          st_nxt = S_FIN;
        end
      end
      S_FIN: if (g_r == neg_one || dstat.done) st_nxt = S_OUT;
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        op_r <= in_op;
        an_r <= wext(in_a_num);
        ad_r <= wext(in_a_den);
        bn_r <= wext(in_b_num);
        bd_r <= wext(in_b_den);
      end
      S_MUL0: p0_r <= mp;
      S_MUL1: p1_r <= mp;
      S_MUL2: p2_r <= mp;
      S_COMB: begin
        if (op_r == OP_ADD) begin
          rn_r <= p0_r + p1_r; rd_r <= p2_r;
          x_r <= p0_r + p1_r; y_r <= p2_r;
        end else if (op_r == OP_SUB) begin
          rn_r <= p0_r - p1_r; rd_r <= p2_r;
          x_r <= p0_r - p1_r; y_r <= p2_r;
        end else if (op_r == OP_MUL || op_r == OP_DIV) begin
          rn_r <= (op_r == OP_MUL) ? p1_r : p0_r; rd_r <= p2_r;
          x_r <= (op_r == OP_MUL) ? p1_r : p0_r; y_r <= p2_r;
        end else begin
          rn_r <= an_r; rd_r <= ad_r;
          x_r <= an_r; y_r <= ad_r;
        end
      end
      S_GCD: begin
        if (rn_r == '0 || rd_r == '0) begin
          rn_r <= '0;
          rd_r <= WIDTH'(1);
        end else if (x_r == '0) g_r <= y_r;
        else if (y_r == '0) g_r <= x_r;
        else if (y_r == neg_one) begin
          x_r <= y_r;
          y_r <= '0;
        end
      end
      S_GWT: if (dstat.done) begin
        x_r <= y_r;
        y_r <= drem;
      end
      S_DVN: if (g_r == neg_one) rn_r <= -rn_r;
      S_DVD: begin
        if (g_r == neg_one) rd_r <= -rd_r;
        else if (dstat.done) rn_r <= dquot;
      end
      S_FIN: begin
        if (g_r == neg_one) begin
          if (rd_r[WIDTH-1]) begin
            rn_r <= -rn_r;
            rd_r <= -rd_r;
          end
        end else if (dstat.done) begin
          rn_r <= dquot[WIDTH-1] ? -rn_r : rn_r;
          rd_r <= dquot[WIDTH-1] ? -dquot : dquot;
        end
      end
      default: ;
    endcase
  end

  assign in_stall     = (st_r != S_IDLE);
  assign out_valid    = (st_r == S_OUT);
  assign out_res_num  = oext(rn_r);
  assign out_res_den  = oext(rd_r);
  assign out_res_zero = (rn_r == '0);
endmodule

// ===== rtl/core/rational_arith_unit_top.sv =====
// Latency depends on the operands: the Euclid remainder steps and the final divisions by the GCD
// run on the shared bit-serial divider unless the divisor is -1.
// Throughput: one request at a time; in_stall is high until the result is taken.
// Reset: synchronous active-low rst_n returns the sequencer and divider to idle.
// A zero numerator or denominator after combining skips the Euclid loop and yields 0/1.
module rational_arith_unit_top #(
  parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rau_pkg::OpWidth-1:0]        in_op,
  input  logic signed [rau_pkg::IoWidth-1:0] in_a_num,
  input  logic signed [rau_pkg::IoWidth-1:0] in_a_den,
  input  logic signed [rau_pkg::IoWidth-1:0] in_b_num,
  input  logic signed [rau_pkg::IoWidth-1:0] in_b_den,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rau_pkg::IoWidth-1:0] out_res_num,
  output logic signed [rau_pkg::IoWidth-1:0] out_res_den,
  output logic                               out_res_zero
);
  import rau_pkg::*;

  // The sequencer owns the multiplier, which forms all three cross products
  // one after another, and the Euclid loop; the divider is shared by the
  // remainder steps and by both final divisions by the GCD unless the divisor is -1.
  div_cmd_t                dcmd;
  div_stat_t               dstat;
  logic signed [WIDTH-1:0] dvd, dvs, dquot, drem;

  rau_seq #(.WIDTH(WIDTH)) u_seq (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .out_valid, .out_stall, .out_res_num,
    .out_res_den, .out_res_zero, .dcmd, .dvd, .dvs, .dstat, .dquot, .drem
  );

  rau_div #(.WIDTH(WIDTH)) u_div (
    .clk, .rst_n, .cmd(dcmd), .dividend(dvd), .divisor(dvs), .stat(dstat),
    .quot(dquot), .rem(drem)
  );
endmodule

// ===== rtl/core/rau_checker.sv =====
module rau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_res_num,
  input logic [31:0] out_res_den,
  input logic        out_res_zero
);
  // A request is not taken while a result is shown.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  // A taken request never yields a result on the next edge.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
  // A zero result is 0/1.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res_zero) |-> (out_res_num == 32'd0 && out_res_den == 32'd1))
    else $error("zero result malformed");
  // A held result stays valid and keeps its numerator.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res_num)))
    else $error("stalled result changed");
endmodule

bind rational_arith_unit_top rau_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_res_num, .out_res_den, .out_res_zero
);
